>>> design/vitp_pkg.sv
// Shared types and constants for the 6522-style interface adapter.
// No dependencies; imported by vitp_core and versatile_interface_timer_ports.
package vitp_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_PIN   = 3'd3,
    REQ_PA_IN = 3'd4,
    REQ_PB_IN = 3'd5
  } vitp_req_t;

  // Control pin selectors
  typedef enum logic [2:0] {
    PIN_CA1 = 3'd0,
    PIN_CA2 = 3'd1,
    PIN_CB1 = 3'd2,
    PIN_CB2 = 3'd3,
    PIN_PA  = 3'd4,
    PIN_PB  = 3'd5
  } vitp_pin_t;

  // Standard register map
  typedef enum logic [3:0] {
    REG_ORB    = 4'd0,
    REG_ORA    = 4'd1,
    REG_DDRB   = 4'd2,
    REG_DDRA   = 4'd3,
    REG_T1CL   = 4'd4,
    REG_T1CH   = 4'd5,
    REG_T1LL   = 4'd6,
    REG_T1LH   = 4'd7,
    REG_T2CL   = 4'd8,
    REG_T2CH   = 4'd9,
    REG_SR     = 4'd10,
    REG_ACR    = 4'd11,
    REG_PCR    = 4'd12,
    REG_IFR    = 4'd13,
    REG_IER    = 4'd14,
    REG_ORA_NH = 4'd15
  } vitp_reg_t;

  // Interrupt flag bits
  localparam logic [7:0] F_CA2 = 8'h01;
  localparam logic [7:0] F_CA1 = 8'h02;
  localparam logic [7:0] F_SR  = 8'h04;
  localparam logic [7:0] F_CB2 = 8'h08;
  localparam logic [7:0] F_CB1 = 8'h10;
  localparam logic [7:0] F_T2  = 8'h20;
  localparam logic [7:0] F_T1  = 8'h40;
  localparam logic [7:0] F_IRQ = 8'h80;
  localparam logic [7:0] FLAG_MASK = 8'h7F;

  // ACR bits
  localparam int ACR_PB7_OUT  = 7;
  localparam int ACR_T1_FREE  = 6;
  localparam int ACR_T2_PULSE = 5;

  // PCR control modes that keep CA2/CB2 flags on port access
  localparam logic [2:0] PCR_IND_NEG = 3'd1;
  localparam logic [2:0] PCR_IND_POS = 3'd3;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] reg_addr;
    logic [7:0] data_value;
    logic [7:0] input_mask;
    logic [2:0] pin_select;
  } vitp_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic       pin_enabled;
    logic [7:0] port_a_level;
    logic [7:0] port_b_level;
  } vitp_result_t;

endpackage

>>> design/vitp_core.sv
// Register file, timers, interrupt logic and port state of the adapter.
// Applies one item per step and produces its result combinationally. Uses vitp_pkg.
module vitp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  vitp_pkg::vitp_item_t  item,
  output vitp_pkg::vitp_result_t result
);
  import vitp_pkg::*;

  logic [7:0]  rf_r [16];
  logic [7:0]  rf_nxt [16];
  logic [15:0] t1_latch_r, t1_latch_nxt, t1_cnt_r, t1_cnt_nxt;
  logic [15:0] t2_latch_r, t2_latch_nxt, t2_cnt_r, t2_cnt_nxt;
  logic        t1_run_r, t1_run_nxt, t1_fired_r, t1_fired_nxt;
  logic        t2_run_r, t2_run_nxt, t2_fired_r, t2_fired_nxt;
  logic        pb7_r, pb7_nxt;
  logic [7:0]  pa_pins_r, pa_pins_nxt, pb_pins_r, pb_pins_nxt;
  logic [7:0]  rd_data;
  logic        pin_en;

  // Next state for one item
  always_comb begin
    logic [7:0] d;
    logic [7:0] acr;
    logic [2:0] mode_a;
    logic [2:0] mode_b;
    logic [7:0] f;
    logic [7:0] pb_new;
    logic       t2_clk;
    logic       free_run;
    logic [7:0] ob_cur;
    logic [7:0] mb_cur;

    d        = item.data_value;
    acr      = rf_r[REG_ACR];
    mode_a   = rf_r[REG_PCR][3:1];
    mode_b   = rf_r[REG_PCR][7:5];
    f        = '0;
    pb_new   = (pb_pins_r & ~item.input_mask) | (item.data_value & item.input_mask);
    t2_clk   = 1'b0;
    free_run = acr[ACR_T1_FREE];

    // current port B drive, PB7 taken from the timer 1 toggle when routed out
    ob_cur = rf_r[REG_ORB];
    mb_cur = rf_r[REG_DDRB];
    if (acr[ACR_PB7_OUT]) begin
      mb_cur[7] = 1'b1;
      ob_cur[7] = pb7_r;
    end

    rf_nxt       = rf_r;
    t1_latch_nxt = t1_latch_r;
    t1_cnt_nxt   = t1_cnt_r;
    t2_latch_nxt = t2_latch_r;
    t2_cnt_nxt   = t2_cnt_r;
    t1_run_nxt   = t1_run_r;
    t1_fired_nxt = t1_fired_r;
    t2_run_nxt   = t2_run_r;
    t2_fired_nxt = t2_fired_r;
    pb7_nxt      = pb7_r;
    pa_pins_nxt  = pa_pins_r;
    pb_pins_nxt  = pb_pins_r;
    rd_data      = '0;
    pin_en       = 1'b0;

    case (item.req_type)
      REQ_READ: begin
        case (item.reg_addr)
          REG_IER: rd_data = rf_r[REG_IER] | F_IRQ;
          REG_IFR: begin
            rd_data = rf_r[REG_IFR];
            rd_data[7] = |(rf_r[REG_IFR] & rf_r[REG_IER] & FLAG_MASK);
          end
          REG_ORA: begin
            rd_data = (rf_r[REG_ORA] & rf_r[REG_DDRA]) | (pa_pins_r & ~rf_r[REG_DDRA]);
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CA1;
            if (mode_a != PCR_IND_NEG && mode_a != PCR_IND_POS) begin
              rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CA2;
            end
          end
          REG_ORA_NH: begin
            rd_data = (rf_r[REG_ORA] & rf_r[REG_DDRA]) | (pa_pins_r & ~rf_r[REG_DDRA]);
          end
          REG_ORB: begin
            rd_data = (ob_cur & mb_cur) | (pb_pins_r & ~mb_cur);
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CB1;
            if (mode_b != PCR_IND_NEG && mode_b != PCR_IND_POS) begin
              rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CB2;
            end
          end
          REG_T1CL: begin
            rd_data = t1_cnt_r[7:0];
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_T1;
          end
          REG_T1CH: rd_data = t1_cnt_r[15:8];
          REG_T1LL: rd_data = t1_latch_r[7:0];
          REG_T1LH: rd_data = t1_latch_r[15:8];
          REG_T2CL: begin
            rd_data = t2_cnt_r[7:0];
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_T2;
          end
          REG_T2CH: rd_data = t2_cnt_r[15:8];
          REG_SR: begin
            rd_data = rf_r[REG_SR];
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_SR;
          end
          default: rd_data = rf_r[item.reg_addr];
        endcase
      end

      REQ_WRITE: begin
        case (item.reg_addr)
          REG_IER: begin
            if (d[7]) begin
              rf_nxt[REG_IER] = rf_r[REG_IER] | (d & FLAG_MASK);
            end else begin
              rf_nxt[REG_IER] = rf_r[REG_IER] & ~d & FLAG_MASK;
            end
          end
          REG_IFR: rf_nxt[REG_IFR] = rf_r[REG_IFR] & ~(d & FLAG_MASK);
          REG_ORA: begin
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CA1;
            if (mode_a != PCR_IND_NEG && mode_a != PCR_IND_POS) begin
              rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CA2;
            end
            rf_nxt[REG_ORA]    = d;
            rf_nxt[REG_ORA_NH] = d;
          end
          REG_ORA_NH: begin
            rf_nxt[REG_ORA]    = d;
            rf_nxt[REG_ORA_NH] = d;
          end
          REG_ORB: begin
            rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CB1;
            if (mode_b != PCR_IND_NEG && mode_b != PCR_IND_POS) begin
              rf_nxt[REG_IFR] = rf_nxt[REG_IFR] & ~F_CB2;
            end
            rf_nxt[REG_ORB] = d;
          end
          REG_T1CL, REG_T1LL: begin
            t1_latch_nxt[7:0] = d;
            rf_nxt[REG_T1CL]  = d;
            rf_nxt[REG_T1LL]  = d;
          end
          REG_T1CH: begin
            t1_latch_nxt[15:8] = d;
            t1_cnt_nxt   = {d, t1_latch_r[7:0]};
            t1_run_nxt   = 1'b1;
            t1_fired_nxt = 1'b0;
            rf_nxt[REG_IFR]  = rf_r[REG_IFR] & ~F_T1;
            rf_nxt[REG_T1CH] = d;
            rf_nxt[REG_T1LH] = d;
            if (acr[ACR_PB7_OUT]) begin
              pb7_nxt = 1'b0;
            end
          end
          REG_T1LH: begin
            t1_latch_nxt[15:8] = d;
            rf_nxt[REG_T1LH]   = d;
            rf_nxt[REG_IFR]    = rf_r[REG_IFR] & ~F_T1;
          end
          REG_T2CL: begin
            t2_latch_nxt[7:0] = d;
            rf_nxt[REG_T2CL]  = d;
          end
          REG_T2CH: begin
            t2_latch_nxt[15:8] = d;
            t2_cnt_nxt   = {d, t2_latch_r[7:0]};
            t2_run_nxt   = 1'b1;
            t2_fired_nxt = 1'b0;
            rf_nxt[REG_IFR]  = rf_r[REG_IFR] & ~F_T2;
            rf_nxt[REG_T2CH] = d;
          end
          REG_SR: begin
            rf_nxt[REG_SR]  = d;
            rf_nxt[REG_IFR] = rf_r[REG_IFR] & ~F_SR;
          end
          default: rf_nxt[item.reg_addr] = d;
        endcase
      end

      REQ_TICK: begin
        // timer 1: reload or park at all ones when it passes zero
        if (t1_run_r) begin
          if (t1_cnt_r == '0) begin
            if (free_run || !t1_fired_r) begin
              rf_nxt[REG_IFR] = rf_r[REG_IFR] | F_T1;
            end
            if (free_run) begin
              t1_cnt_nxt = t1_latch_r;
              if (acr[ACR_PB7_OUT]) begin
                pb7_nxt = ~pb7_r;
              end
            end else begin
              t1_cnt_nxt = TIMER_MAX;
              if (acr[ACR_PB7_OUT]) begin
                pb7_nxt = 1'b1;
              end
              t1_fired_nxt = 1'b1;
            end
          end else begin
            t1_cnt_nxt = t1_cnt_r - 16'd1;
          end
        end
        t2_clk = t2_run_r && !acr[ACR_T2_PULSE];
      end

      REQ_PIN: begin
        case (item.pin_select)
          PIN_CA1: f = F_CA1;
          PIN_CA2: f = F_CA2;
          PIN_CB1: f = F_CB1;
          PIN_CB2: f = F_CB2;
          default: f = '0;
        endcase
        rf_nxt[REG_IFR] = rf_r[REG_IFR] | f;
        pin_en = |(rf_r[REG_IER] & f);
      end

      REQ_PA_IN: begin
        pa_pins_nxt = (pa_pins_r & ~item.input_mask) | (item.data_value & item.input_mask);
      end

      REQ_PB_IN: begin
        pb_pins_nxt = pb_new;
        // PB6 falling edge counts timer 2 in pulse mode
        t2_clk = t2_run_r && acr[ACR_T2_PULSE] && !rf_r[REG_DDRB][6]
                 && pb_pins_r[6] && !pb_new[6];
      end

      default: ;
    endcase

    // timer 2 decrement, shared by tick and pulse counting
    if (t2_clk) begin
      if (t2_cnt_r == '0) begin
        if (!t2_fired_r) begin
          rf_nxt[REG_IFR] = rf_nxt[REG_IFR] | F_T2;
          t2_fired_nxt    = 1'b1;
        end
        t2_cnt_nxt = TIMER_MAX;
      end else begin
        t2_cnt_nxt = t2_cnt_r - 16'd1;
      end
    end
  end

  // Result fields from the state after the item
  always_comb begin
    logic [7:0] ob;
    logic [7:0] mb;
    ob = rf_nxt[REG_ORB];
    mb = rf_nxt[REG_DDRB];
    if (rf_nxt[REG_ACR][ACR_PB7_OUT]) begin
      mb[7] = 1'b1;
      ob[7] = pb7_nxt;
    end
    result.read_data    = rd_data;
    result.irq_out      = |(rf_nxt[REG_IFR] & rf_nxt[REG_IER] & FLAG_MASK);
    result.pin_enabled  = pin_en;
    result.port_a_level = (rf_nxt[REG_ORA] & rf_nxt[REG_DDRA])
                          | (pa_pins_nxt & ~rf_nxt[REG_DDRA]);
    result.port_b_level = (ob & mb) | (pb_pins_nxt & ~mb);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= '0;
      end
      t1_latch_r <= '0;
      t1_cnt_r   <= '0;
      t2_latch_r <= '0;
      t2_cnt_r   <= '0;
      t1_run_r   <= 1'b0;
      t1_fired_r <= 1'b0;
      t2_run_r   <= 1'b0;
      t2_fired_r <= 1'b0;
      pb7_r      <= 1'b1;
      pa_pins_r  <= 8'hFF;
      pb_pins_r  <= 8'hFF;
    end else if (step) begin
      rf_r       <= rf_nxt;
      t1_latch_r <= t1_latch_nxt;
      t1_cnt_r   <= t1_cnt_nxt;
      t2_latch_r <= t2_latch_nxt;
      t2_cnt_r   <= t2_cnt_nxt;
      t1_run_r   <= t1_run_nxt;
      t1_fired_r <= t1_fired_nxt;
      t2_run_r   <= t2_run_nxt;
      t2_fired_r <= t2_fired_nxt;
      pb7_r      <= pb7_nxt;
      pa_pins_r  <= pa_pins_nxt;
      pb_pins_r  <= pb_pins_nxt;
    end
  end

endmodule

>>> design/versatile_interface_timer_ports.sv
// Top level of the 6522-style interface adapter: input register, core, result register.
// Depends on vitp_pkg and vitp_core.
//
// Usage:
//   Input channel (in_*): one item per handshake. in_tuser carries the item kind
//   (read, write, tick, pin event, port A input, port B input); in_tdata carries
//   the register index, data byte, input mask and pin selector.
//   Result channel (out_*): exactly one result item per input item, in order,
//   carrying read data, IRQ level, pin-enable status and both port levels.
// Flow: an accepted item is registered in the input register, processed by the
//   core once the result register is free or draining, and its result loaded into
//   the result register, which raises out_tvalid.
// Throughput: one item per cycle unless a result is held; every state update is a
//   single pass of the core logic between the input register and the result register.
// Reset (rst_n low, synchronous): both stages empty, register file and timers
//   cleared, PB7 toggle high, port input pins all ones.
// Stall: when out_tready is low a held result blocks the core; the input
//   register keeps its item, or takes one more if it was empty, and then
//   in_tready stays low until the result is taken.
module versatile_interface_timer_ports (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_addr[3:0], data_value[11:4], input_mask[19:12],
                                  // pin_select[22:20], zero[23]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // read_data[7:0], irq_out[8], pin_enabled[9],
                                  // port_a_level[17:10], port_b_level[25:18], zero[31:26]
);
  import vitp_pkg::*;

  vitp_item_t   in_item_r;
  logic         in_vld_r;
  vitp_result_t out_r;
  logic         out_vld_r;
  vitp_result_t core_res;
  logic         adv;

  // Stage control: core advances when the result register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type   <= in_tuser;
      in_item_r.reg_addr   <= in_tdata[3:0];
      in_item_r.data_value <= in_tdata[11:4];
      in_item_r.input_mask <= in_tdata[19:12];
      in_item_r.pin_select <= in_tdata[22:20];
    end
  end

  vitp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (in_item_r),
    .result (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= core_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.port_b_level, out_r.port_a_level,
                       out_r.pin_enabled, out_r.irq_out, out_r.read_data};

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_tready)
    else $error("input stage empty but not ready");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_vld_r)
    else $error("accepted item lost from input stage");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed item produced no result");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_item_r.req_type != REQ_READ |=> out_r.read_data == 8'd0)
    else $error("read data nonzero for a non-read item");

  a_pin_en: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_item_r.req_type != REQ_PIN |=> !out_r.pin_enabled)
    else $error("pin enable set for a non-pin item");

endmodule

>>> sim/via_result_checker.sv
// Result checker for the 6522-style interface adapter: watches both stream channels,
// predicts each result from its own copy of the adapter state and compares field by field.
// Depends on vitp_pkg for the item kinds, register map and flag constants.
module via_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import vitp_pkg::*;

  // Shadow copy of the adapter state
  logic [7:0]  regs [16];
  logic [15:0] t1_latch, t1_count, t2_latch, t2_count;
  logic        t1_run, t1_fired, t2_run, t2_fired;
  logic        pb7_tog;
  logic [7:0]  pa_pins, pb_pins;

  vitp_result_t awaited_results [$];
  int           mismatches;

  function automatic void model_reset();
    foreach (regs[i]) regs[i] = '0;
    t1_latch = '0;
    t1_count = '0;
    t2_latch = '0;
    t2_count = '0;
    t1_run   = 1'b0;
    t1_fired = 1'b0;
    t2_run   = 1'b0;
    t2_fired = 1'b0;
    pb7_tog  = 1'b1;
    pa_pins  = 8'hFF;
    pb_pins  = 8'hFF;
  endfunction

  function automatic logic irq_now();
    return |(regs[REG_IFR] & regs[REG_IER] & FLAG_MASK);
  endfunction

  function automatic logic [7:0] level_a();
    return (regs[REG_ORA] & regs[REG_DDRA]) | (pa_pins & ~regs[REG_DDRA]);
  endfunction

  // PB7 follows the timer 1 toggle when the ACR routes it out
  function automatic logic [7:0] level_b();
    logic [7:0] drive, dir;
    drive = regs[REG_ORB];
    dir   = regs[REG_DDRB];
    if (regs[REG_ACR][ACR_PB7_OUT]) begin
      dir[7]   = 1'b1;
      drive[7] = pb7_tog;
    end
    return (drive & dir) | (pb_pins & ~dir);
  endfunction

  // Port accesses clear CA1/CB1, and CA2/CB2 unless in an independent mode
  function automatic void clear_a_flags();
    logic [2:0] mode;
    mode = regs[REG_PCR][3:1];
    regs[REG_IFR] &= ~F_CA1;
    if (mode != PCR_IND_NEG && mode != PCR_IND_POS) regs[REG_IFR] &= ~F_CA2;
  endfunction

  function automatic void clear_b_flags();
    logic [2:0] mode;
    mode = regs[REG_PCR][7:5];
    regs[REG_IFR] &= ~F_CB1;
    if (mode != PCR_IND_NEG && mode != PCR_IND_POS) regs[REG_IFR] &= ~F_CB2;
  endfunction

  // Timer 2 flags once per load, then wraps and keeps counting
  function automatic void t2_count_down();
    if (t2_count == 16'h0000) begin
      if (!t2_fired) begin
        regs[REG_IFR] |= F_T2;
        t2_fired = 1'b1;
      end
      t2_count = TIMER_MAX;
    end else begin
      t2_count--;
    end
  endfunction

  function automatic void tick_timers();
    logic free_run;
    if (t1_run) begin
      if (t1_count == 16'h0000) begin
        free_run = regs[REG_ACR][ACR_T1_FREE];
        if (free_run || !t1_fired) regs[REG_IFR] |= F_T1;
        if (free_run) begin
          t1_count = t1_latch;
          if (regs[REG_ACR][ACR_PB7_OUT]) pb7_tog = ~pb7_tog;
        end else begin
          t1_count = TIMER_MAX;
          if (regs[REG_ACR][ACR_PB7_OUT]) pb7_tog = 1'b1;
          t1_fired = 1'b1;
        end
      end else begin
        t1_count--;
      end
    end
    if (t2_run && !regs[REG_ACR][ACR_T2_PULSE]) t2_count_down();
  endfunction

  function automatic logic [7:0] bus_read(logic [3:0] addr);
    case (addr)
      REG_IER:    return regs[REG_IER] | F_IRQ;
      REG_IFR:    return regs[REG_IFR] | (irq_now() ? F_IRQ : 8'h00);
      REG_ORA: begin
        clear_a_flags();
        return level_a();
      end
      REG_ORA_NH: return level_a();
      REG_ORB: begin
        clear_b_flags();
        return level_b();
      end
      REG_T1CL: begin
        regs[REG_IFR] &= ~F_T1;
        return t1_count[7:0];
      end
      REG_T1CH:   return t1_count[15:8];
      REG_T1LL:   return t1_latch[7:0];
      REG_T1LH:   return t1_latch[15:8];
      REG_T2CL: begin
        regs[REG_IFR] &= ~F_T2;
        return t2_count[7:0];
      end
      REG_T2CH:   return t2_count[15:8];
      REG_SR: begin
        regs[REG_IFR] &= ~F_SR;
        return regs[REG_SR];
      end
      default:    return regs[addr];
    endcase
  endfunction

  function automatic void bus_write(logic [3:0] addr, logic [7:0] d);
    case (addr)
      // bit 7 picks set or clear and is never stored
      REG_IER: begin
        if (d[7]) regs[REG_IER] |= d & FLAG_MASK;
        else regs[REG_IER] &= ~d & FLAG_MASK;
      end
      REG_IFR: regs[REG_IFR] &= ~(d & FLAG_MASK);
      REG_ORA: begin
        clear_a_flags();
        regs[REG_ORA]    = d;
        regs[REG_ORA_NH] = d;
      end
      REG_ORA_NH: begin
        regs[REG_ORA]    = d;
        regs[REG_ORA_NH] = d;
      end
      REG_ORB: begin
        clear_b_flags();
        regs[REG_ORB] = d;
      end
      REG_T1CL, REG_T1LL: begin
        t1_latch[7:0]  = d;
        regs[REG_T1CL] = d;
        regs[REG_T1LL] = d;
      end
      // high byte loads the counter and starts timer 1
      REG_T1CH: begin
        t1_latch[15:8] = d;
        t1_count       = t1_latch;
        t1_run         = 1'b1;
        t1_fired       = 1'b0;
        regs[REG_IFR] &= ~F_T1;
        regs[REG_T1CH] = d;
        regs[REG_T1LH] = d;
        if (regs[REG_ACR][ACR_PB7_OUT]) pb7_tog = 1'b0;
      end
      REG_T1LH: begin
        t1_latch[15:8] = d;
        regs[REG_T1LH] = d;
        regs[REG_IFR] &= ~F_T1;
      end
      REG_T2CL: begin
        t2_latch[7:0]  = d;
        regs[REG_T2CL] = d;
      end
      REG_T2CH: begin
        t2_latch[15:8] = d;
        t2_count       = t2_latch;
        t2_run         = 1'b1;
        t2_fired       = 1'b0;
        regs[REG_IFR] &= ~F_T2;
        regs[REG_T2CH] = d;
      end
      REG_SR: begin
        regs[REG_SR]   = d;
        regs[REG_IFR] &= ~F_SR;
      end
      default: regs[addr] = d;
    endcase
  endfunction

  // Applies one item to the shadow state and returns the result it must produce
  function automatic vitp_result_t adapter_step(vitp_item_t it);
    vitp_result_t res;
    logic [7:0]   pin_flag, prev_b, next_b;
    res = '0;
    case (it.req_type)
      REQ_READ:  res.read_data = bus_read(it.reg_addr);
      REQ_WRITE: bus_write(it.reg_addr, it.data_value);
      REQ_TICK:  tick_timers();
      REQ_PIN: begin
        case (it.pin_select)
          PIN_CA1: pin_flag = F_CA1;
          PIN_CA2: pin_flag = F_CA2;
          PIN_CB1: pin_flag = F_CB1;
          PIN_CB2: pin_flag = F_CB2;
          default: pin_flag = 8'h00;
        endcase
        regs[REG_IFR] |= pin_flag;
        res.pin_enabled = |(regs[REG_IER] & pin_flag);
      end
      REQ_PA_IN: pa_pins = (pa_pins & ~it.input_mask) | (it.data_value & it.input_mask);
      REQ_PB_IN: begin
        prev_b  = pb_pins;
        next_b  = (prev_b & ~it.input_mask) | (it.data_value & it.input_mask);
        pb_pins = next_b;
        // pulse counting: falling edge on PB6 while it is an input
        if (t2_run && regs[REG_ACR][ACR_T2_PULSE] && !regs[REG_DDRB][6]
            && prev_b[6] && !next_b[6])
          t2_count_down();
      end
      default: ;
    endcase
    res.irq_out      = irq_now();
    res.port_a_level = level_a();
    res.port_b_level = level_b();
    return res;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both channels at each edge; results are checked before new items are queued
  always @(posedge clk) begin
    vitp_item_t   item;
    vitp_result_t want;
    if (!rst_n) begin
      model_reset();
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %08h", $time, out_tdata);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("read_data", want.read_data, out_tdata[7:0]);
          compare_field("irq_out", {7'd0, want.irq_out}, {7'd0, out_tdata[8]});
          compare_field("pin_enabled", {7'd0, want.pin_enabled}, {7'd0, out_tdata[9]});
          compare_field("port_a_level", want.port_a_level, out_tdata[17:10]);
          compare_field("port_b_level", want.port_b_level, out_tdata[25:18]);
        end
      end
      if (in_tvalid && in_tready) begin
        item.req_type   = in_tuser;
        item.reg_addr   = in_tdata[3:0];
        item.data_value = in_tdata[11:4];
        item.input_mask = in_tdata[19:12];
        item.pin_select = in_tdata[22:20];
        awaited_results.push_back(adapter_step(item));
      end
    end
    fail_count    <= mismatches;
    pending_count <= awaited_results.size();
  end

endmodule

>>> sim/tb_versatile_interface_timer_ports.sv
// Testbench top for the 6522-style interface adapter: clock, reset, stimulus and verdict.
// Depends on vitp_pkg, the adapter RTL and via_result_checker, which does the result checking.
module tb_versatile_interface_timer_ports;
  timeunit 1ns;
  timeprecision 1ps;
  import vitp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;

  // selector codes outside the defined sets
  localparam logic [2:0] REQ_RESERVED = 3'd7;
  localparam logic [2:0] REQ_SPARE    = 3'd6;
  localparam logic [2:0] PIN_RESERVED = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;

  int   fail_count;
  int   pending_count;
  int   items_sent   = 0;
  logic steady       = 1'b0;
  logic hold_request = 1'b0;

  logic [3:0] port_regs [5] = '{REG_ORB, REG_ORA, REG_ORA_NH, REG_IFR, REG_IER};

  versatile_interface_timer_ports DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  via_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus one long hold-off to fill the pipe
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Offer one item, with random idle cycles ahead of it, and wait for acceptance
  task automatic offer(input logic [2:0] kind, input logic [3:0] addr, input logic [7:0] data,
                       input logic [7:0] mask, input logic [2:0] pin);
    while (!steady && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, pin, mask, data, addr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [7:0] data);
    offer(REQ_WRITE, addr, data, 8'($urandom), 3'($urandom));
  endtask

  task automatic read_reg(input logic [3:0] addr);
    offer(REQ_READ, addr, 8'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic timer_tick();
    offer(REQ_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic pin_event(input logic [2:0] pin);
    offer(REQ_PIN, 4'($urandom), 8'($urandom), 8'($urandom), pin);
  endtask

  task automatic port_input(input logic [2:0] kind, input logic [7:0] data,
                            input logic [7:0] mask);
    offer(kind, 4'($urandom), data, mask, 3'($urandom));
  endtask

  initial begin
    int directed_total;
    int pick, n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset reads, port levels, every pin, flag rules, both timers
    read_reg(REG_IER);
    write_reg(REG_IER, 8'hFF);
    write_reg(REG_DDRA, 8'hF0);
    write_reg(REG_ORA, 8'hA5);
    port_input(REQ_PA_IN, 8'h00, 8'hFF);
    write_reg(REG_DDRB, 8'h0F);
    port_input(REQ_PB_IN, 8'h5A, 8'hFF);
    pin_event(PIN_CA1);
    pin_event(PIN_CA2);
    pin_event(PIN_CB1);
    pin_event(PIN_CB2);
    pin_event(PIN_PA);
    pin_event(PIN_PB);
    pin_event(PIN_RESERVED);
    read_reg(REG_IFR);
    write_reg(REG_PCR, 8'h22);   // CA2 and CB2 in independent mode
    read_reg(REG_ORA);
    write_reg(REG_IFR, 8'hFF);
    write_reg(REG_ACR, 8'hC0);   // timer 1 free running, PB7 output
    write_reg(REG_T1CL, 8'h01);
    write_reg(REG_T1CH, 8'h00);
    repeat (3) timer_tick();
    write_reg(REG_ACR, 8'h20);   // timer 2 counts PB6 pulses
    write_reg(REG_T2CH, 8'h00);
    port_input(REQ_PB_IN, 8'h00, 8'h40);
    offer(REQ_SPARE, 4'h0, 8'h00, 8'h00, 3'd0);
    offer(REQ_RESERVED, 4'hF, 8'hFF, 8'hFF, 3'd7);
    directed_total = items_sent;

    // Random: mostly timer and port sequences with random content, some noise
    while (items_sent < directed_total + RANDOM_ITEMS) begin
      if (items_sent >= directed_total + 100) hold_request <= 1'b1;
      steady <= (items_sent >= directed_total + 500) && (items_sent < directed_total + 800);
      pick = $urandom_range(99);
      if (pick < 30) begin
        // timer 1: short load, then mostly ticks
        write_reg(REG_ACR, 8'($urandom));
        if ($urandom_range(3) == 0) write_reg(REG_T1LH, 8'h00);
        write_reg($urandom_range(1) ? REG_T1CL : REG_T1LL, 8'($urandom_range(12)));
        write_reg(REG_T1CH, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00);
        n = $urandom_range(24, 3);
        repeat (n) begin
          case ($urandom_range(9))
            7:       read_reg(REG_IFR);
            8:       read_reg(4'($urandom_range(7, 4)));
            9: begin
              if ($urandom_range(1)) write_reg(REG_T1LL, 8'($urandom_range(12)));
              else write_reg(REG_IFR, 8'($urandom));
            end
            default: timer_tick();
          endcase
        end
      end else if (pick < 50) begin
        // timer 2: tick or PB6 pulse counting
        write_reg(REG_DDRB, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom) & 8'hBF);
        write_reg(REG_ACR, 8'($urandom));
        write_reg(REG_T2CL, 8'($urandom_range(6)));
        write_reg(REG_T2CH, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00);
        n = $urandom_range(24, 3);
        repeat (n) begin
          case ($urandom_range(7))
            0, 1, 2: port_input(REQ_PB_IN, 8'($urandom),
                                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom) | 8'h40);
            3:       read_reg(REG_IFR);
            4:       read_reg($urandom_range(1) ? REG_T2CL : REG_T2CH);
            default: timer_tick();
          endcase
        end
      end else if (pick < 75) begin
        // handshake pins, interrupt enables and port traffic
        n = $urandom_range(16, 4);
        repeat (n) begin
          case ($urandom_range(9))
            0:       write_reg(REG_PCR, 8'($urandom));
            1:       write_reg(REG_IER, 8'($urandom));
            2, 3:    pin_event(3'($urandom));
            4, 5:    read_reg(port_regs[$urandom_range(4)]);
            6:       write_reg(port_regs[$urandom_range(2)], 8'($urandom));
            7:       write_reg($urandom_range(1) ? REG_DDRA : REG_DDRB, 8'($urandom));
            8: begin
              if ($urandom_range(1)) port_input(REQ_PA_IN, 8'($urandom), 8'($urandom));
              else port_input(REQ_PB_IN, 8'($urandom), 8'($urandom));
            end
            default: begin
              if ($urandom_range(1)) write_reg(REG_SR, 8'($urandom));
              else read_reg(REG_SR);
            end
          endcase
        end
      end else begin
        // fully random items, unknown kinds and selectors included
        repeat ($urandom_range(4, 1))
          offer(3'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every result, then keep watching for stray output
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> versatile_interface_timer_ports.f
design/vitp_pkg.sv
design/vitp_core.sv
design/versatile_interface_timer_ports.sv
sim/via_result_checker.sv
sim/tb_versatile_interface_timer_ports.sv
